>>> hdl/frame_allocator_heap_break_mapper_macros.svh
// Assertion macros for the frame allocator top level.
`ifndef FRAME_ALLOCATOR_HEAP_BREAK_MAPPER_MACROS_SVH
`define FRAME_ALLOCATOR_HEAP_BREAK_MAPPER_MACROS_SVH
// Condition that must hold at every clock edge outside reset.
`define FAM_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant violated");
// Antecedent in one cycle requires the consequent in the next cycle.
`define FAM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sequence violated");
`endif

>>> hdl/fam_pkg.sv
// Package with the constants, codes and types of the frame allocator.
`timescale 1ns / 1ps
package fam_pkg;
  localparam int PAGE_ENTRIES = 256;
  localparam int FRAMES       = 256;
  localparam int PAGE_SHIFT   = 13;
  localparam int FB_WORDS     = FRAMES / 16;
  localparam logic [2:0] PROT_RW = 3'd3;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0, OP_FREE = 2'd1, OP_BREAK = 2'd2, OP_READ = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_BELOW_HEAP = 3'd1, ST_OVER_STACK = 3'd2, ST_DECREASE = 3'd3,
    ST_NO_FRAMES = 3'd4, ST_INVALID = 3'd5, ST_ALREADY_FREE = 3'd6
  } status_t;

  localparam logic [1:0] CFG_VM_ON = 2'd0;
  localparam logic [1:0] CFG_HEAP  = 2'd1;
  localparam logic [1:0] CFG_STACK = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_AL_RD, S_AL_CK, S_FR_RD, S_FR_CK, S_SH_RD, S_SH_CK,
    S_SH_FB, S_GR_RD, S_GR_CK, S_RE_RD, S_RE_CK, S_DONE
  } state_t;

  typedef struct packed {
    logic       vm_on;
    logic [7:0] heap_first_page;
    logic [8:0] stack_base_page;
  } cfg_t;

  typedef struct packed {
    logic        we;
    logic [3:0]  addr;
    logic [15:0] wdata;
  } fb_port_t;

  typedef struct packed {
    logic        we;
    logic [7:0]  addr;
    logic [11:0] wdata;
  } pt_port_t;

  typedef struct packed {
    logic [8:0] flush_count;
    logic [7:0] flush_first_page;
    logic [2:0] entry_prot;
    logic       entry_valid;
    logic [7:0] frame_out;
    status_t    status;
  } result_t;
endpackage

>>> hdl/fam_bitmap.sv
// Used-frame bitmap memory, sixteen frames per word, registered read.
`timescale 1ns / 1ps
module fam_bitmap (
  input  logic               clk,
  input  fam_pkg::fb_port_t  port,
  output logic [15:0]        rdata
);
  logic [15:0] mem [fam_pkg::FB_WORDS];
  always_ff @(posedge clk) begin
    if (port.we) begin
      mem[port.addr] <= port.wdata;
    end
    rdata <= mem[port.addr];
  end
endmodule

>>> hdl/fam_ptab.sv
// Page table memory, one twelve-bit entry per page, registered read.
`timescale 1ns / 1ps
module fam_ptab (
  input  logic               clk,
  input  fam_pkg::pt_port_t  port,
  output logic [11:0]        rdata
);
  logic [11:0] mem [fam_pkg::PAGE_ENTRIES];
  always_ff @(posedge clk) begin
    if (port.we) begin
      mem[port.addr] <= port.wdata;
    end
    rdata <= mem[port.addr];
  end
endmodule

>>> hdl/fam_seq.sv
// Request sequencer: walks the bitmap and page table per request.
`timescale 1ns / 1ps
module fam_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  fam_pkg::cfg_t      cfg,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic [1:0]         req_op,
  input  logic [20:0]        req_break,
  input  logic [7:0]         req_ff,
  input  logic [7:0]         req_idx,
  output logic               res_valid,
  input  logic               res_ready,
  output fam_pkg::result_t   res,
  output fam_pkg::fb_port_t  fb_port,
  input  logic [15:0]        fb_rdata,
  output fam_pkg::pt_port_t  pt_port,
  input  logic [11:0]        pt_rdata
);
  fam_pkg::state_t  state_r, state_nxt;
  logic [7:0]       cnt_r, cnt_nxt;
  logic [7:0]       end_r, end_nxt;
  logic [3:0]       scan_r, scan_nxt;
  logic [8:0]       done_r, done_nxt;
  logic [20:0]      break_r, break_nxt;
  logic [20:0]      brk_r, brk_nxt;
  logic [7:0]       ff_r, ff_nxt;
  logic [7:0]       idx_r, idx_nxt;
  logic [7:0]       ef_r, ef_nxt;
  fam_pkg::result_t acc_r, acc_nxt;
  fam_pkg::result_t out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic       word_full;
  logic [3:0] free_bit;
  logic [7:0] np, cp;
  logic       load;

  always_comb begin
    free_bit = 4'd0;
    for (int b = 15; b >= 0; b--) begin
      if (!fb_rdata[b]) free_bit = 4'(b);
    end
  end
  assign word_full = &fb_rdata;
  assign np = req_break[20:fam_pkg::PAGE_SHIFT];
  assign cp = break_r[20:fam_pkg::PAGE_SHIFT];
  assign req_ready = (state_r == fam_pkg::S_IDLE);
  assign load = (state_r == fam_pkg::S_DONE) && (!out_valid_r || res_ready);
  assign res_valid = out_valid_r;
  assign res = out_r;

  // Next state and register updates.
  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; end_nxt = end_r; scan_nxt = scan_r;
    done_nxt = done_r; break_nxt = break_r; brk_nxt = brk_r; ff_nxt = ff_r;
    idx_nxt = idx_r; ef_nxt = ef_r; acc_nxt = acc_r; out_nxt = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && res_ready) out_valid_nxt = 1'b0;
    unique case (state_r)
      fam_pkg::S_CLEAR: begin
        cnt_nxt = cnt_r + 8'd1;
        if (cnt_r == 8'hFF) state_nxt = fam_pkg::S_IDLE;
      end
      fam_pkg::S_IDLE: begin
        if (req_valid) begin
          acc_nxt = '0;
          brk_nxt = req_break; ff_nxt = req_ff; idx_nxt = req_idx;
          scan_nxt = 4'd0; done_nxt = 9'd0;
          state_nxt = fam_pkg::S_DONE;
          unique case (fam_pkg::op_t'(req_op))
            fam_pkg::OP_ALLOC: state_nxt = fam_pkg::S_AL_RD;
            fam_pkg::OP_FREE: begin
              if ({1'b0, req_ff} >= 9'(fam_pkg::FRAMES)) acc_nxt.status = fam_pkg::ST_INVALID;
              else state_nxt = fam_pkg::S_FR_RD;
            end
            fam_pkg::OP_READ: state_nxt = fam_pkg::S_RE_RD;
            fam_pkg::OP_BREAK: begin
              if (np < cfg.heap_first_page) begin
                acc_nxt.status = fam_pkg::ST_BELOW_HEAP;
              end else if ({1'b0, np} >= cfg.stack_base_page ||
                           {1'b0, np} > 9'(fam_pkg::PAGE_ENTRIES)) begin
                acc_nxt.status = fam_pkg::ST_OVER_STACK;
              end else if (!cfg.vm_on) begin
                if (req_break < break_r) acc_nxt.status = fam_pkg::ST_DECREASE;
                else break_nxt = req_break;
              end else if (np < cp) begin
                cnt_nxt = np; end_nxt = cp;
                acc_nxt.flush_first_page = np;
                acc_nxt.flush_count = {1'b0, cp} - {1'b0, np};
                state_nxt = fam_pkg::S_SH_RD;
              end else if (np > cp) begin
                cnt_nxt = cp; end_nxt = np;
                acc_nxt.flush_first_page = cp;
                state_nxt = fam_pkg::S_GR_RD;
              end else begin
                break_nxt = req_break;
              end
            end
            default: state_nxt = fam_pkg::S_DONE;
          endcase
        end
      end
      fam_pkg::S_AL_RD: state_nxt = fam_pkg::S_AL_CK;
      fam_pkg::S_AL_CK: begin
        if (!word_full) begin
          acc_nxt.frame_out = {scan_r, free_bit};
          state_nxt = fam_pkg::S_DONE;
        end else if (scan_r == 4'(fam_pkg::FB_WORDS - 1)) begin
          acc_nxt.status = fam_pkg::ST_NO_FRAMES;
          state_nxt = fam_pkg::S_DONE;
        end else begin
          scan_nxt = scan_r + 4'd1;
          state_nxt = fam_pkg::S_AL_RD;
        end
      end
      fam_pkg::S_FR_RD: state_nxt = fam_pkg::S_FR_CK;
      fam_pkg::S_FR_CK: begin
        if (!fb_rdata[ff_r[3:0]]) acc_nxt.status = fam_pkg::ST_ALREADY_FREE;
        state_nxt = fam_pkg::S_DONE;
      end
      fam_pkg::S_SH_RD: state_nxt = fam_pkg::S_SH_CK;
      fam_pkg::S_SH_CK, fam_pkg::S_SH_FB: begin
        if (state_r == fam_pkg::S_SH_CK && pt_rdata[11]) begin
          ef_nxt = pt_rdata[7:0];
          state_nxt = fam_pkg::S_SH_FB;
        end else if (cnt_r == end_r - 8'd1) begin
          break_nxt = brk_r;
          state_nxt = fam_pkg::S_DONE;
        end else begin
          cnt_nxt = cnt_r + 8'd1;
          state_nxt = fam_pkg::S_SH_RD;
        end
      end
      fam_pkg::S_GR_RD: state_nxt = fam_pkg::S_GR_CK;
      fam_pkg::S_GR_CK: begin
        if (!word_full) begin
          done_nxt = done_r + 9'd1;
          if (cnt_r == end_r - 8'd1) begin
            acc_nxt.flush_count = done_r + 9'd1;
            break_nxt = brk_r;
            state_nxt = fam_pkg::S_DONE;
          end else begin
            cnt_nxt = cnt_r + 8'd1;
            state_nxt = fam_pkg::S_GR_RD;
          end
        end else if (scan_r == 4'(fam_pkg::FB_WORDS - 1)) begin
          acc_nxt.status = fam_pkg::ST_NO_FRAMES;
          acc_nxt.flush_count = done_r;
          state_nxt = fam_pkg::S_DONE;
        end else begin
          scan_nxt = scan_r + 4'd1;
          state_nxt = fam_pkg::S_GR_RD;
        end
      end
      fam_pkg::S_RE_RD: state_nxt = fam_pkg::S_RE_CK;
      fam_pkg::S_RE_CK: begin
        if ({1'b0, idx_r} < 9'(fam_pkg::PAGE_ENTRIES)) begin
          acc_nxt.frame_out = pt_rdata[7:0];
          acc_nxt.entry_valid = pt_rdata[11];
          acc_nxt.entry_prot = pt_rdata[10:8];
        end
        state_nxt = fam_pkg::S_DONE;
      end
      fam_pkg::S_DONE: begin
        if (load) begin
          out_nxt = acc_r;
          out_valid_nxt = 1'b1;
          state_nxt = fam_pkg::S_IDLE;
        end
      end
      default: state_nxt = fam_pkg::S_IDLE;
    endcase
  end

  // Memory port drive.
  always_comb begin
    fb_port = '{we: 1'b0, addr: scan_r, wdata: fb_rdata | (16'd1 << free_bit)};
    pt_port = '{we: 1'b0, addr: cnt_r, wdata: 12'd0};
    unique case (state_r)
      fam_pkg::S_CLEAR: begin
        fb_port = '{we: 1'b1, addr: cnt_r[3:0], wdata: 16'd0};
        pt_port.we = 1'b1;
      end
      fam_pkg::S_AL_CK: fb_port.we = !word_full;
      fam_pkg::S_FR_RD: fb_port.addr = ff_r[7:4];
      fam_pkg::S_FR_CK: begin
        fb_port.addr = ff_r[7:4];
        fb_port.we = fb_rdata[ff_r[3:0]];
        fb_port.wdata = fb_rdata & ~(16'd1 << ff_r[3:0]);
      end
      fam_pkg::S_SH_CK: begin
        fb_port.addr = pt_rdata[7:4];
        pt_port.we = pt_rdata[11];
      end
      fam_pkg::S_SH_FB: begin
        fb_port.addr = ef_r[7:4];
        fb_port.we = ({1'b0, ef_r} < 9'(fam_pkg::FRAMES));
        fb_port.wdata = fb_rdata & ~(16'd1 << ef_r[3:0]);
      end
      fam_pkg::S_GR_CK: begin
        fb_port.we = !word_full;
        pt_port.we = !word_full;
        pt_port.wdata = {1'b1, fam_pkg::PROT_RW, scan_r, free_bit};
      end
      fam_pkg::S_RE_RD: pt_port.addr = idx_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fam_pkg::S_CLEAR;
      cnt_r <= 8'd0;
      break_r <= 21'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      break_r <= break_nxt;
      out_valid_r <= out_valid_nxt;
    end
    end_r <= end_nxt; scan_r <= scan_nxt; done_r <= done_nxt; brk_r <= brk_nxt;
    ff_r <= ff_nxt; idx_r <= idx_nxt; ef_r <= ef_nxt; acc_r <= acc_nxt; out_r <= out_nxt;
  end
endmodule

>>> hdl/frame_allocator_heap_break_mapper.sv
// Top level of the frame allocator with heap break and page table.
//
// Requests arrive as transactions on the in_ channel: the opcode in in_tuser,
// the request fields in in_tdata. Every request yields exactly one result
// transaction on the out_ channel. The block works on one request at a time;
// in_tready is high only while the sequencer is idle.
// Allocate scans the bitmap word by word for a free frame; free and read do
// one memory read and check; a rejected, paging-off or same-page break goes
// straight to the result. Shrinking the break releases the frame of each
// valid page entry; growing maps each page to a free frame, skipping full
// bitmap words, and the word scan pointer carries over from page to page.
// A result sits in an output register; the block accepts the next request
// while it waits, and holds the following result until out_tready frees it.
// After reset a clearing pass zeroes the page table and the bitmap;
// in_tready stays low meanwhile. Configuration writes on cfg_ are taken at
// any time and are meant to be issued only while the block is idle.
`timescale 1ns / 1ps
module frame_allocator_heap_break_mapper (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,  // opcode
  input  logic [39:0] in_tdata,  // break_request, frame_to_free, entry_index
  output logic        out_tvalid,
  input  logic        out_tready,
  // status, frame_out, entry_valid, entry_prot, flush_first_page, flush_count
  output logic [31:0] out_tdata
);
  `include "frame_allocator_heap_break_mapper_macros.svh"

  fam_pkg::cfg_t     cfg_r, cfg_nxt;
  fam_pkg::fb_port_t fb_port;
  fam_pkg::pt_port_t pt_port;
  logic [15:0]       fb_rdata;
  logic [11:0]       pt_rdata;
  fam_pkg::result_t  res;
  logic              nofr_result;

  // Configuration registers; writes beyond the list are ignored.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        fam_pkg::CFG_VM_ON: cfg_nxt.vm_on = cfg_wdata[0];
        fam_pkg::CFG_HEAP:  cfg_nxt.heap_first_page = cfg_wdata[7:0];
        fam_pkg::CFG_STACK: cfg_nxt.stack_base_page = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{vm_on: 1'b0, heap_first_page: 8'd0, stack_base_page: 9'd256};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  fam_seq u_seq (
    .clk, .rst_n, .cfg(cfg_r),
    .req_valid(in_tvalid), .req_ready(in_tready), .req_op(in_tuser),
    .req_break(in_tdata[20:0]), .req_ff(in_tdata[28:21]), .req_idx(in_tdata[36:29]),
    .res_valid(out_tvalid), .res_ready(out_tready), .res,
    .fb_port, .fb_rdata, .pt_port, .pt_rdata
  );

  fam_bitmap u_bitmap (.clk, .port(fb_port), .rdata(fb_rdata));
  fam_ptab   u_ptab   (.clk, .port(pt_port), .rdata(pt_rdata));

  assign out_tdata = {res.flush_count, res.flush_first_page, res.entry_prot,
                      res.entry_valid, res.frame_out, 3'(res.status)};

  assign nofr_result = out_tvalid && (res.status == fam_pkg::ST_NO_FRAMES);

  // One request at a time: accepting one holds in_tready low until it is done.
  `FAM_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready)
  // Out-of-frames results never carry a frame number.
  `FAM_ASSERT_ALWAYS(a_nofr_frame, !nofr_result || res.frame_out == 8'd0)
  // A flush range never exceeds the page table.
  `FAM_ASSERT_ALWAYS(a_flush_range, !out_tvalid || out_tdata[31:23] <= 9'd256)
endmodule
